@@ rtl/core/decimal_long_multiplier_core_defines.svh @@
// Assertion helpers for the RTL of the decimal long multiplier core.
// Define ASSERT_OFF to compile the checks out.
`ifndef DECIMAL_LONG_MULTIPLIER_CORE_DEFINES_SVH
`define DECIMAL_LONG_MULTIPLIER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DLM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define DLM_ASSERT(lbl, prop, msg)
`define DLM_NEVER(lbl, cond, msg)
`endif

`endif

@@ rtl/core/dlm_pkg.sv @@
package dlm_pkg;

    // Longest operand, and longest product that may be delivered, in digits; PROD_DEPTH is the product memory depth.
    localparam int MAX_DIGITS = 32;
    localparam int PROD_DEPTH = 2 * MAX_DIGITS;
    localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int PADDR_W    = $clog2(PROD_DEPTH);
    localparam int TOT_W      = $clog2(PROD_DEPTH + 1);

    localparam logic REQ_LOAD_A = 1'b0;
    localparam logic REQ_LOAD_B = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_DIGIT = 2'd1,
        STAT_TOO_LONG  = 2'd2
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [3:0] digit_in;
        logic       last_digit;
    } t_req;

    typedef struct packed {
        logic [3:0] digit_out;
        logic       last_out;
        t_status    status;
    } t_res;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic shift_b;
        logic clear_b;
        logic clear_acc;
        logic step;
    } t_cell_ctrl;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_bcd_pair;

    // Tens and units of a value below 128; the quotient uses the reciprocal 103/1024.
    function automatic t_bcd_pair bcd_split(input logic [6:0] v);
        logic [13:0] prod;
        t_bcd_pair   res;
        prod      = 14'(v) * 14'd103;
        res.tens  = prod[13:10];
        res.units = 4'(v - ({3'd0, res.tens} * 7'd10));
        return res;
    endfunction

endpackage

@@ rtl/core/dlm_cell.sv @@
module dlm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dlm_pkg::t_cell_ctrl i_ctrl,
    input  logic [3:0]          i_a,
    input  logic [3:0]          i_b_in,
    input  logic [3:0]          i_d_in,
    output logic [3:0]          o_b,
    output logic [3:0]          o_r
);
    import dlm_pkg::*;

    // One decade of the accumulator: digit r_d plus a carry r_c of the same weight.
    logic [3:0] r_b;
    logic [3:0] r_d;
    logic [3:0] r_c;
    logic [7:0] w_pp;
    logic [6:0] w_sum;
    t_bcd_pair  w_split;

    assign w_pp    = {4'd0, i_a} * {4'd0, r_b};
    assign w_sum   = 7'({4'd0, r_d} + {4'd0, r_c} + w_pp);
    assign w_split = bcd_split(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= 4'd0;
        end else if (i_ctrl.clear_b) begin
            r_b <= 4'd0;
        end else if (i_ctrl.shift_b) begin
            r_b <= i_b_in;
        end
    end

    // The units move one decade down each step; the tens stay here as carry.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear_acc) begin
            r_d <= 4'd0;
            r_c <= 4'd0;
        end else if (i_ctrl.step) begin
            r_d <= i_d_in;
            r_c <= w_split.tens;
        end
    end

    assign o_b = r_b;
    assign o_r = w_split.units;

endmodule

@@ rtl/core/decimal_long_multiplier_core.sv @@
// Decimal long multiplier. Each word written with start high while busy is low loads one
// decimal digit, most significant first: operand A first, then operand B, last_digit
// marking each operand's final digit. A load gives no result. The word that ends B starts
// the multiply; that request then holds busy high through the multiply and the read-back
// of the product. The cell row retires one product digit per cycle, and the single read
// port of the product memory returns one digit per cycle.
// Results appear on o_res for one cycle each, marked by o_strobe, most significant digit
// first with leading zeros stripped; the receiver cannot hold them off and must take every
// one. The digits stream in consecutive cycles, and the last one is on the ports in the
// first idle cycle.
// A digit above 9 in the request yields one word with status 1; an operand or product
// longer than MAX_DIGITS yields one word with status 2; both carry digit 0 and last_out 1
// and arrive the cycle after the word that ends B, or after the multiply for a long product.
`include "decimal_long_multiplier_core_defines.svh"

module decimal_long_multiplier_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  dlm_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output dlm_pkg::t_res o_res
);
    import dlm_pkg::*;

    // PREP clears the accumulator and primes the operand A read, MUL runs the cell row,
    // FIN checks the product length, OUT reads the product back, DRAIN lets the read
    // pipeline empty so that no later result can land on the same cycle.
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_FIN   = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_DRAIN = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_la, n_la;
    logic [LEN_W-1:0]   r_lb, n_lb;
    logic               r_bad, n_bad;
    logic               r_long, n_long;
    logic               r_a_closed, n_a_closed;
    logic [LEN_W-1:0]   r_a_left, n_a_left;
    logic [PADDR_W-1:0] r_step, n_step;
    logic [PADDR_W-1:0] r_top, n_top;
    logic               r_nz, n_nz;
    logic [PADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic               r_rd_valid, n_rd_valid;
    logic               r_rd_last, n_rd_last;
    logic               r_out_stb, n_out_stb;
    t_res               r_res, n_res;

    // Operand A and product memories.
    logic [3:0]         r_a_mem [MAX_DIGITS];
    logic [3:0]         r_a_rdata;
    logic [3:0]         r_p_mem [PROD_DEPTH];
    logic [3:0]         r_p_rdata;

    logic               w_accept;
    logic               w_is_a;
    logic               w_is_b;
    logic               w_digit_bad;
    logic [LEN_W-1:0]   w_la_eff;
    logic               w_a_full;
    logic               w_b_full;
    logic               w_a_we;
    logic [LEN_W-1:0]   w_lb_next;
    logic               w_bad_next;
    logic               w_long_next;
    logic [LEN_W-1:0]   w_a_rptr;
    logic [TOT_W-1:0]   w_total;
    logic [3:0]         w_a_digit;
    t_cell_ctrl         w_ctrl;
    logic [3:0]         w_bchain [MAX_DIGITS + 1];
    logic [3:0]         w_rchain [MAX_DIGITS + 1];

    assign busy        = (r_state != ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_is_a      = w_accept && (i_req.req_type == REQ_LOAD_A);
    assign w_is_b      = w_accept && (i_req.req_type == REQ_LOAD_B);
    assign w_digit_bad = (i_req.digit_in > 4'd9);

    // An A digit after A's last digit starts a new operand A.
    assign w_la_eff    = r_a_closed ? '0 : r_la;
    assign w_a_full    = (w_la_eff >= LEN_W'(MAX_DIGITS));
    assign w_b_full    = (r_lb >= LEN_W'(MAX_DIGITS));
    assign w_a_we      = w_is_a && !w_a_full;
    assign w_lb_next   = w_b_full ? r_lb : r_lb + LEN_W'(1);
    assign w_bad_next  = r_bad || w_digit_bad;
    assign w_long_next = r_long || (w_is_a && w_a_full) || (w_is_b && w_b_full);
    assign w_total     = TOT_W'(r_la) + TOT_W'(r_lb);

    // A digits are fed least significant first; the read is issued one step ahead.
    assign w_a_rptr  = (r_state == ST_PREP) ? r_la - LEN_W'(1) : r_a_left - LEN_W'(2);
    assign w_a_digit = (r_a_left != '0) ? r_a_rdata : 4'd0;

    always_comb begin
        n_state    = r_state;
        n_la       = r_la;
        n_lb       = r_lb;
        n_bad      = r_bad;
        n_long     = r_long;
        n_a_closed = r_a_closed;
        n_a_left   = r_a_left;
        n_step     = r_step;
        n_top      = r_top;
        n_nz       = r_nz;
        n_rd_idx   = r_rd_idx;
        n_rd_valid = 1'b0;
        n_rd_last  = r_rd_last;
        n_out_stb  = 1'b0;
        n_res      = r_res;
        w_ctrl     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_is_a) begin
                    n_la       = w_a_full ? w_la_eff : w_la_eff + LEN_W'(1);
                    n_a_closed = i_req.last_digit;
                    n_bad      = w_bad_next;
                    n_long     = w_long_next;
                end
                if (w_is_b) begin
                    n_lb           = w_lb_next;
                    n_bad          = w_bad_next;
                    n_long         = w_long_next;
                    w_ctrl.shift_b = !w_b_full;
                    if (i_req.last_digit) begin
                        if (w_bad_next || w_long_next) begin
                            n_out_stb      = 1'b1;
                            n_res          = '{digit_out: 4'd0, last_out: 1'b1,
                                               status: w_bad_next ? STAT_BAD_DIGIT
                                                                  : STAT_TOO_LONG};
                            n_la           = '0;
                            n_lb           = '0;
                            n_bad          = 1'b0;
                            n_long         = 1'b0;
                            n_a_closed     = 1'b0;
                            w_ctrl.clear_b = 1'b1;
                        end else begin
                            n_state = ST_PREP;
                        end
                    end
                end
            end
            ST_PREP: begin
                w_ctrl.clear_acc = 1'b1;
                n_a_left         = r_la;
                n_step           = '0;
                n_top            = '0;
                n_nz             = 1'b0;
                n_state          = ST_MUL;
            end
            ST_MUL: begin
                // Cell 0 retires one final product digit per step, lowest decade first.
                w_ctrl.step = 1'b1;
                if (r_a_left != '0) begin
                    n_a_left = r_a_left - LEN_W'(1);
                end
                n_step = r_step + PADDR_W'(1);
                if (w_rchain[0] != 4'd0) begin
                    n_top = r_step;
                    n_nz  = 1'b1;
                end
                if (TOT_W'(r_step) + TOT_W'(1) == w_total) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_la           = '0;
                n_lb           = '0;
                n_bad          = 1'b0;
                n_long         = 1'b0;
                n_a_closed     = 1'b0;
                w_ctrl.clear_b = 1'b1;
                if (r_nz && (r_top >= PADDR_W'(MAX_DIGITS))) begin
                    n_out_stb = 1'b1;
                    n_res     = '{digit_out: 4'd0, last_out: 1'b1, status: STAT_TOO_LONG};
                    n_state   = ST_IDLE;
                end else begin
                    // A zero product still delivers its lowest digit.
                    n_rd_idx = r_nz ? r_top : '0;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                n_rd_valid = 1'b1;
                n_rd_last  = (r_rd_idx == '0);
                if (r_rd_idx == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx - PADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (r_rd_valid) begin
            n_out_stb = 1'b1;
            n_res     = '{digit_out: r_p_rdata, last_out: r_rd_last, status: STAT_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_la       <= '0;
            r_lb       <= '0;
            r_bad      <= 1'b0;
            r_long     <= 1'b0;
            r_a_closed <= 1'b0;
            r_a_left   <= '0;
            r_step     <= '0;
            r_top      <= '0;
            r_nz       <= 1'b0;
            r_rd_idx   <= '0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
            r_out_stb  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_la       <= n_la;
            r_lb       <= n_lb;
            r_bad      <= n_bad;
            r_long     <= n_long;
            r_a_closed <= n_a_closed;
            r_a_left   <= n_a_left;
            r_step     <= n_step;
            r_top      <= n_top;
            r_nz       <= n_nz;
            r_rd_idx   <= n_rd_idx;
            r_rd_valid <= n_rd_valid;
            r_rd_last  <= n_rd_last;
            r_out_stb  <= n_out_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_a_mem[w_la_eff[ADDR_W-1:0]] <= i_req.digit_in;
        end
        r_a_rdata <= r_a_mem[w_a_rptr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_p_mem[r_step] <= w_rchain[0];
        end
        r_p_rdata <= r_p_mem[r_rd_idx];
    end

    // Cell g holds the B digit of weight ten to the g and one accumulator decade.
    // B digits shift in from cell 0 upward; product units shift from the top down.
    assign w_bchain[0]          = i_req.digit_in;
    assign w_rchain[MAX_DIGITS] = 4'd0;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        dlm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_a     (w_a_digit),
            .i_b_in  (w_bchain[g]),
            .i_d_in  (w_rchain[g + 1]),
            .o_b     (w_bchain[g + 1]),
            .o_r     (w_rchain[g])
        );
    end

    assign o_strobe = r_out_stb;
    assign o_res    = r_res;

    `DLM_NEVER(a_no_result_in_mul, (r_state == ST_MUL) && o_strobe, "result during multiply")
    `DLM_ASSERT(a_feed_bounded, (r_state == ST_MUL) |-> (r_a_left <= r_la), "A feed overran")
    `DLM_ASSERT(a_read_delivers, r_rd_valid |=> o_strobe, "product read not delivered")
    `DLM_NEVER(a_idle_pipe_empty, !busy && r_rd_valid, "idle with product read pending")

endmodule
